/* src/tfs_pkg.sv */
package tfs_pkg;

  // default sizes of the face store and of the centre coordinates
  localparam int unsigned MAX_FACES_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned RECT_W     = 12;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned HALF_W     = DIM_W - 1;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned RAND_W     = 16;
  localparam int unsigned CNTR_W     = 16;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  // shared divider
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned FRAC_STEPS = 15;

  // register reset values
  localparam logic [PERIOD_W-1:0] SWITCH_PERIOD_RST = 16'd10;
  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST   = 12'd640;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST  = 12'd480;

  // saturation limits of the q1.15 position
  localparam logic [POS_W-1:0] POS_MAX = 16'h7fff;
  localparam logic [POS_W-1:0] POS_MIN = 16'h8000;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SWITCH_PERIOD = 2'd0,
    REG_FRAME_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT  = 2'd2
  } cfg_reg_e;

  // operand set for the shared divider
  typedef enum logic [1:0] {
    DIV_PERIOD = 2'd0,
    DIV_RANDOM = 2'd1,
    DIV_POS_X  = 2'd2,
    DIV_POS_Y  = 2'd3
  } div_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     calc_centre;
    logic     square_x;
    logic     square_y;
    logic     update_best;
    logic     div_start;
    div_sel_e div_sel;
    logic     pick_best;
    logic     pick_random;
    logic     mem_read;
    logic     load_prev;
    logic     store_x;
    logic     store_y;
    logic     emit_face;
    logic     emit_none;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic face_present;
    logic last_face;
    logic store_full;
    logic div_done;
    logic period_hit;
  } status_t;

endpackage

/* src/tfs_divider.sv */
module tfs_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tfs_pkg::DIV_W-1:0]      rem_init_i,
  input  logic [tfs_pkg::DIV_W-1:0]      dividend_i,
  input  logic [tfs_pkg::DIV_W-1:0]      divisor_i,
  input  logic [tfs_pkg::DIV_CNT_W-1:0]  steps_i,
  output logic                           done_o,
  output logic [tfs_pkg::DIV_W-1:0]      remainder_o,
  output logic [tfs_pkg::DIV_W-1:0]      quotient_o
);

  localparam int unsigned W = tfs_pkg::DIV_W;

  logic                          busy_q, busy_d;
  logic [tfs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]                  rem_q, dvd_q, div_q, quo_q;
  logic [W:0]                    trial, diff;
  logic                          ge;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  assign done_o      = busy_q && (cnt_q == '0);
  assign remainder_o = rem_q;
  assign quotient_o  = quo_q;

  // step counter
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // partial remainder, dividend and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  // a new division is only launched once the previous one has finished
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (!busy_q || (cnt_q == '0)))
    else $error("divider restarted while a division was running");

endmodule

/* src/tfs_datapath.sv */
module tfs_datapath #(
  parameter int unsigned MAX_FACES  = tfs_pkg::MAX_FACES_DEF,
  parameter int unsigned COORD_BITS = tfs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tfs_pkg::cmd_t                   cmd_i,
  output tfs_pkg::status_t                status_o,
  input  logic                            face_present_i,
  input  logic [tfs_pkg::RECT_W-1:0]      rect_x_i,
  input  logic [tfs_pkg::RECT_W-1:0]      rect_y_i,
  input  logic [tfs_pkg::RECT_W-1:0]      rect_w_i,
  input  logic [tfs_pkg::RECT_W-1:0]      rect_h_i,
  input  logic                            last_face_i,
  input  logic [tfs_pkg::RAND_W-1:0]      random_value_i,
  input  logic                            cfg_we_i,
  input  logic [tfs_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [tfs_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic                            out_strobe_o,
  output logic                            face_detected_o,
  output logic [tfs_pkg::INDEX_W-1:0]     chosen_index_o,
  output logic signed [tfs_pkg::POS_W-1:0] pos_x_o,
  output logic signed [tfs_pkg::POS_W-1:0] pos_y_o
);

  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned IDX_W   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_FACES + 1);
  localparam int unsigned ENTRY_W = 2 * CB;
  localparam int unsigned DIST_W  = (2 * CB + 1 > 32) ? 32 : 2 * CB + 1;
  localparam int unsigned MAG_W   = (CB > tfs_pkg::HALF_W) ? CB : tfs_pkg::HALF_W;
  localparam int unsigned SUM_W   = tfs_pkg::RECT_W + 1;
  localparam int unsigned CMP_W   = (SUM_W > CB) ? SUM_W : CB;

  // rectangle centre, saturated to the coordinate range
  function automatic logic [CB-1:0] centre_of(input logic [tfs_pkg::RECT_W-1:0] pos,
                                              input logic [tfs_pkg::RECT_W-1:0] size);
    logic [CMP_W-1:0] sum;
    logic [CMP_W-1:0] lim;
    sum = CMP_W'(pos) + CMP_W'(size[tfs_pkg::RECT_W-1:1]);
    lim = CMP_W'({CB{1'b1}});
    return (sum > lim) ? {CB{1'b1}} : sum[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // half of the frame size, never zero
  function automatic logic [tfs_pkg::HALF_W-1:0] half_of(input logic [tfs_pkg::DIM_W-1:0] size);
    logic [tfs_pkg::HALF_W-1:0] h;
    h = size[tfs_pkg::DIM_W-1:1];
    return (h == '0) ? tfs_pkg::HALF_W'(1) : h;
  endfunction

  // distance of the centre from the frame middle
  function automatic logic [MAG_W-1:0] mag_of(input logic [CB-1:0] c,
                                              input logic [tfs_pkg::HALF_W-1:0] h);
    logic [MAG_W-1:0] ce;
    logic [MAG_W-1:0] he;
    ce = MAG_W'(c);
    he = MAG_W'(h);
    return (ce >= he) ? (ce - he) : (he - ce);
  endfunction

  // signed q1.15 position from the fraction quotient, saturated
  function automatic logic [tfs_pkg::POS_W-1:0] pos_of(
      input logic [CB-1:0]                     c,
      input logic [tfs_pkg::HALF_W-1:0]        h,
      input logic [tfs_pkg::FRAC_STEPS-1:0]    quo);
    logic                      neg;
    logic                      sat;
    logic [tfs_pkg::POS_W-1:0] mag_q;
    neg   = MAG_W'(c) < MAG_W'(h);
    sat   = mag_of(c, h) >= MAG_W'(h);
    mag_q = tfs_pkg::POS_W'(quo);
    if (sat) begin
      return neg ? tfs_pkg::POS_MIN : tfs_pkg::POS_MAX;
    end
    return neg ? (tfs_pkg::POS_W'(0) - mag_q) : mag_q;
  endfunction

  // configuration registers
  logic [tfs_pkg::PERIOD_W-1:0] switch_period_q;
  logic [tfs_pkg::DIM_W-1:0]    frame_width_q, frame_height_q;

  // captured transaction
  logic                          face_present_q, last_face_q;
  logic [tfs_pkg::RECT_W-1:0]    rect_x_q, rect_y_q, rect_w_q, rect_h_q;
  logic [tfs_pkg::RAND_W-1:0]    random_q;

  // tracking state
  logic [tfs_pkg::CNTR_W-1:0]    frame_counter_q;
  logic [CB-1:0]                 prev_cx_q, prev_cy_q;
  logic [DIST_W-1:0]             best_dist_q;
  logic [IDX_W-1:0]              best_idx_q, chosen_q;
  logic [CNT_W-1:0]              face_count_q;
  logic [tfs_pkg::POS_W-1:0]     last_pos_x_q, last_pos_y_q;

  // working registers
  logic [CB-1:0]                 dx_q, dy_q;
  logic [2*CB-1:0]               sqx_q, sqy_q;
  logic [ENTRY_W-1:0]            rd_q;
  logic [ENTRY_W-1:0]            center_mem [MAX_FACES];

  // outputs
  logic                          out_strobe_q, face_detected_q;
  logic [tfs_pkg::INDEX_W-1:0]   chosen_index_q;
  logic [tfs_pkg::POS_W-1:0]     pos_x_q, pos_y_q;

  logic [CB-1:0]                 cx, cy, mul_in;
  logic [2*CB-1:0]               prod;
  logic [2*CB:0]                 dist_sum;
  logic [DIST_W-1:0]             distance;
  logic [tfs_pkg::HALF_W-1:0]    half_w, half_h;
  logic [tfs_pkg::PERIOD_W-1:0]  period;
  logic                          store_full;

  logic [tfs_pkg::DIV_W-1:0]     div_rem_init, div_dividend, div_divisor;
  logic [tfs_pkg::DIV_CNT_W-1:0] div_steps;
  logic                          div_done;
  logic [tfs_pkg::DIV_W-1:0]     div_rem, div_quo;

  assign cx         = centre_of(rect_x_q, rect_w_q);
  assign cy         = centre_of(rect_y_q, rect_h_q);
  assign half_w     = half_of(frame_width_q);
  assign half_h     = half_of(frame_height_q);
  assign period     = (switch_period_q == '0) ? tfs_pkg::PERIOD_W'(1) : switch_period_q;
  assign store_full = face_count_q == CNT_W'(MAX_FACES);

  // one shared squarer
  assign mul_in   = cmd_i.square_y ? dy_q : dx_q;
  assign prod     = {{CB{1'b0}}, mul_in} * {{CB{1'b0}}, mul_in};
  assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign distance = dist_sum[DIST_W-1:0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_period_q <= tfs_pkg::SWITCH_PERIOD_RST;
      frame_width_q   <= tfs_pkg::FRAME_WIDTH_RST;
      frame_height_q  <= tfs_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (tfs_pkg::cfg_reg_e'(cfg_addr_i))
        tfs_pkg::REG_SWITCH_PERIOD: switch_period_q <= cfg_wdata_i[tfs_pkg::PERIOD_W-1:0];
        tfs_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_wdata_i[tfs_pkg::DIM_W-1:0];
        tfs_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_wdata_i[tfs_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      face_present_q <= face_present_i;
      last_face_q    <= last_face_i;
      rect_x_q       <= rect_x_i;
      rect_y_q       <= rect_y_i;
      rect_w_q       <= rect_w_i;
      rect_h_q       <= rect_h_i;
      random_q       <= random_value_i;
    end
  end

  // centre offsets and their squares
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_centre) begin
      dx_q <= abs_diff(cx, prev_cx_q);
      dy_q <= abs_diff(cy, prev_cy_q);
    end
    if (cmd_i.square_x) begin
      sqx_q <= prod;
    end
    if (cmd_i.square_y) begin
      sqy_q <= prod;
    end
  end

  // centre store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_centre) begin
      center_mem[face_count_q[IDX_W-1:0]] <= {cx, cy};
    end
    if (cmd_i.mem_read) begin
      rd_q <= center_mem[chosen_q];
    end
  end

  // tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_counter_q <= '0;
      prev_cx_q       <= '0;
      prev_cy_q       <= '0;
      best_dist_q     <= '0;
      best_idx_q      <= '0;
      face_count_q    <= '0;
      chosen_q        <= '0;
      last_pos_x_q    <= '0;
      last_pos_y_q    <= '0;
    end else begin
      if (cmd_i.update_best) begin
        if ((face_count_q == '0) || (distance < best_dist_q)) begin
          best_dist_q <= distance;
          best_idx_q  <= face_count_q[IDX_W-1:0];
        end
        face_count_q <= face_count_q + 1'b1;
      end
      if (cmd_i.pick_best) begin
        chosen_q <= best_idx_q;
      end
      if (cmd_i.pick_random) begin
        chosen_q <= div_rem[IDX_W-1:0];
      end
      if (cmd_i.load_prev) begin
        prev_cx_q <= rd_q[ENTRY_W-1:CB];
        prev_cy_q <= rd_q[CB-1:0];
      end
      if (cmd_i.store_x) begin
        last_pos_x_q <= pos_of(prev_cx_q, half_w, div_quo[tfs_pkg::FRAC_STEPS-1:0]);
      end
      if (cmd_i.store_y) begin
        last_pos_y_q <= pos_of(prev_cy_q, half_h, div_quo[tfs_pkg::FRAC_STEPS-1:0]);
      end
      if (cmd_i.emit_face) begin
        frame_counter_q <= frame_counter_q + 1'b1;
      end
      // frame ends: start a fresh list
      if (cmd_i.emit_face || cmd_i.emit_none) begin
        face_count_q <= '0;
        best_dist_q  <= '0;
        best_idx_q   <= '0;
      end
    end
  end

  // divider operands
  always_comb begin
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = tfs_pkg::DIV_W'(1);
    div_steps    = tfs_pkg::DIV_CNT_W'(tfs_pkg::DIV_W);
    case (cmd_i.div_sel)
      tfs_pkg::DIV_PERIOD: begin
        div_dividend = tfs_pkg::DIV_W'(frame_counter_q);
        div_divisor  = tfs_pkg::DIV_W'(period);
      end
      tfs_pkg::DIV_RANDOM: begin
        div_dividend = tfs_pkg::DIV_W'(random_q);
        div_divisor  = tfs_pkg::DIV_W'(face_count_q);
      end
      tfs_pkg::DIV_POS_X: begin
        div_rem_init = tfs_pkg::DIV_W'(mag_of(rd_q[ENTRY_W-1:CB], half_w));
        div_divisor  = tfs_pkg::DIV_W'(half_w);
        div_steps    = tfs_pkg::DIV_CNT_W'(tfs_pkg::FRAC_STEPS);
      end
      tfs_pkg::DIV_POS_Y: begin
        div_rem_init = tfs_pkg::DIV_W'(mag_of(prev_cy_q, half_h));
        div_divisor  = tfs_pkg::DIV_W'(half_h);
        div_steps    = tfs_pkg::DIV_CNT_W'(tfs_pkg::FRAC_STEPS);
      end
      default: ;
    endcase
  end

  tfs_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .rem_init_i  (div_rem_init),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .steps_i     (div_steps),
    .done_o      (div_done),
    .remainder_o (div_rem),
    .quotient_o  (div_quo)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_strobe_q <= 1'b0;
    end else begin
      out_strobe_q <= cmd_i.emit_face || cmd_i.emit_none;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_face) begin
      face_detected_q <= 1'b1;
      chosen_index_q  <= tfs_pkg::INDEX_W'(chosen_q);
      pos_x_q         <= last_pos_x_q;
      pos_y_q         <= last_pos_y_q;
    end else if (cmd_i.emit_none) begin
      face_detected_q <= 1'b0;
      chosen_index_q  <= '0;
      pos_x_q         <= last_pos_x_q;
      pos_y_q         <= last_pos_y_q;
    end
  end

  assign out_strobe_o    = out_strobe_q;
  assign face_detected_o = face_detected_q;
  assign chosen_index_o  = chosen_index_q;
  assign pos_x_o         = $signed(pos_x_q);
  assign pos_y_o         = $signed(pos_y_q);

  assign status_o.face_present = face_present_q;
  assign status_o.last_face    = last_face_q;
  assign status_o.store_full   = store_full;
  assign status_o.div_done     = div_done;
  assign status_o.period_hit   = div_rem == '0;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    face_count_q <= CNT_W'(MAX_FACES))
    else $error("face count beyond store depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.calc_centre |-> !store_full)
    else $error("centre written into a full store");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_q |=> !out_strobe_q)
    else $error("results on two consecutive cycles");

endmodule

/* src/tfs_ctrl.sv */
module tfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  tfs_pkg::status_t status_i,
  output tfs_pkg::cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CENTRE = 12'b0000_0000_0010,
    S_SQX    = 12'b0000_0000_0100,
    S_SQY    = 12'b0000_0000_1000,
    S_UPDATE = 12'b0000_0001_0000,
    S_PMOD   = 12'b0000_0010_0000,
    S_RMOD   = 12'b0000_0100_0000,
    S_READ   = 12'b0000_1000_0000,
    S_LOAD   = 12'b0001_0000_0000,
    S_QX     = 12'b0010_0000_0000,
    S_QY     = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = state_q != S_IDLE;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = tfs_pkg::DIV_PERIOD;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CENTRE;
        end
      end
      S_CENTRE: begin
        if (!status_i.face_present) begin
          cmd_o.emit_none = 1'b1;
          state_d         = S_IDLE;
        end else if (status_i.store_full) begin
          if (status_i.last_face) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_PMOD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.calc_centre = 1'b1;
          state_d           = S_SQX;
        end
      end
      S_SQX: begin
        cmd_o.square_x = 1'b1;
        state_d        = S_SQY;
      end
      S_SQY: begin
        cmd_o.square_y = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update_best = 1'b1;
        if (status_i.last_face) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_PMOD;
        end else begin
          state_d = S_IDLE;
        end
      end
      // frame counter modulo period decides random or nearest
      S_PMOD: begin
        if (status_i.div_done) begin
          if (status_i.period_hit) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = tfs_pkg::DIV_RANDOM;
            state_d         = S_RMOD;
          end else begin
            cmd_o.pick_best = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      S_RMOD: begin
        if (status_i.div_done) begin
          cmd_o.pick_random = 1'b1;
          state_d           = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_prev = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = tfs_pkg::DIV_POS_X;
        state_d         = S_QX;
      end
      S_QX: begin
        if (status_i.div_done) begin
          cmd_o.store_x   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = tfs_pkg::DIV_POS_Y;
          state_d         = S_QY;
        end
      end
      S_QY: begin
        if (status_i.div_done) begin
          cmd_o.store_y = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit_face = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/tracked_face_selector.sv */
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------------------------
// face in  | input     | start high, busy low    | face_present, rect_x/y/w/h, last_face,
//          |           |                         | random_value
// result   | output    | out_strobe_o, 1 cycle   | face_detected, chosen_index, pos_x, pos_y
// config   | input     | cfg_we_i, no wait       | cfg_addr_i, cfg_wdata_i
//
// a face that is not the last of its frame passes the centre, square x, square y and update states back to idle,
// a no-face transaction goes back to idle from the centre state with its result in the cycle after
// for the last face of a frame the shared one-bit-per-cycle divider runs the
// period modulo, the random modulo when a random choice is due, and both
// 15-bit position fractions one after another
// the result shows in the cycle after the emit state and cannot be held off
// reset is asynchronous and active low; the centre store needs no clearing pass
module tracked_face_selector #(
  parameter int unsigned MAX_FACES  = tfs_pkg::MAX_FACES_DEF,
  parameter int unsigned COORD_BITS = tfs_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             face_present_i,
  input  logic [tfs_pkg::RECT_W-1:0]       rect_x_i,
  input  logic [tfs_pkg::RECT_W-1:0]       rect_y_i,
  input  logic [tfs_pkg::RECT_W-1:0]       rect_w_i,
  input  logic [tfs_pkg::RECT_W-1:0]       rect_h_i,
  input  logic                             last_face_i,
  input  logic [tfs_pkg::RAND_W-1:0]       random_value_i,
  input  logic                             cfg_we_i,
  input  logic [tfs_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [tfs_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                             out_strobe_o,
  output logic                             face_detected_o,
  output logic [tfs_pkg::INDEX_W-1:0]      chosen_index_o,
  output logic signed [tfs_pkg::POS_W-1:0] pos_x_o,
  output logic signed [tfs_pkg::POS_W-1:0] pos_y_o
);

  tfs_pkg::cmd_t    cmd;
  tfs_pkg::status_t status;

  tfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tfs_datapath #(
    .MAX_FACES  (MAX_FACES),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .face_present_i  (face_present_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_w_i        (rect_w_i),
    .rect_h_i        (rect_h_i),
    .last_face_i     (last_face_i),
    .random_value_i  (random_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_strobe_o    (out_strobe_o),
    .face_detected_o (face_detected_o),
    .chosen_index_o  (chosen_index_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o)
  );

endmodule
